// ----- hw/rtl/self_calibrating_compass_heading_core_defines.svh -----
// Assertion macros for the compass heading core.
// Included by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef SELF_CALIBRATING_COMPASS_HEADING_CORE_DEFINES_SVH
`define SELF_CALIBRATING_COMPASS_HEADING_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SCCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scch assertion failed");
// Next-cycle implication, checked outside reset.
`define SCCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scch assertion failed");
`else
`define SCCH_ASSERT_IMP(lbl, ante, cons)
`define SCCH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/scch_pkg.sv -----
// Shared constants and the arctangent table of the compass heading core.
// No dependencies; used by scch_cordic and the top level.
`timescale 1ns / 1ps
`default_nettype none
package scch_pkg;
  // CORDIC iteration count and fixed-point layout (angles in Q16 degrees).
  localparam int ITERS         = 23;
  localparam int ITER_W        = 5;
  localparam int DEG_FRAC      = 16;
  localparam int PRESCALE_BITS = 24;
  localparam int ANG_W         = 22;
  localparam int Z_W           = 24;
  localparam int PHI_W         = 25;
  localparam int HEAD_W        = 9;

  localparam logic [ANG_W-1:0] DEG45  = ANG_W'(45 * 65536);
  localparam logic [PHI_W-1:0] DEG90  = PHI_W'(90 * 65536);
  localparam logic [PHI_W-1:0] DEG180 = PHI_W'(180 * 65536);
  localparam logic [HEAD_W-1:0] FULL_TURN = HEAD_W'(360);

  // round(atan(2^-i) * 65536 * 180 / pi)
  function automatic logic [ANG_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117305;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/self_calibrating_compass_heading_core.sv -----
// Compass heading core: running min/max calibration, two serial products, CORDIC atan2.
// Depends on scch_pkg, scch_mult, scch_cordic and the defines header.
//
// Usage: each input beat on s_axis carries one X/Y magnetometer sample. The
// block widens its per-axis minimum and maximum with it and returns exactly
// one beat on m_axis: the heading 1..360 degrees in tdata, and in tuser a
// flag that is 1 once both axes have a nonzero span (heading 0 before that).
// Each sample passes through the min/max update and recentering, the
// bit-serial multipliers forming the two scaled components, the octant
// reduction, the CORDIC loop, and the steps that finish and load the output.
// On an axis or a diagonal the loop is skipped, and uncalibrated samples
// skip the multipliers and the CORDIC. One sample is worked on at a time; the
// next beat is taken only after the result is loaded into the output register.
// The result sits in an output register, so a new sample is taken while the
// previous result waits; if the receiver stalls, a finished result holds
// back new samples until the output register drains.
// Reset clears the min/max to zero, empties the output and returns to idle.
`timescale 1ns / 1ps
`default_nettype none
`include "self_calibrating_compass_heading_core_defines.svh"
module self_calibrating_compass_heading_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] mag_x, [31:16] mag_y
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [8:0] heading_deg, rest zero
  output logic             m_axis_tuser    // [0] calibrated
);
  localparam int N  = SAMPLE_BITS;
  localparam int PW = 2 * N + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_CTR  = 6'b000100,
    S_MUL  = 6'b001000,
    S_OCT  = 6'b010000,
    S_COR  = 6'b100000
  } state_t;

  state_t state;
  logic fin;

  logic signed [N-1:0] xs, ys, x_min, x_max, y_min, y_max;
  logic cal, cal_c, num_neg, den_neg, swap;
  logic [N:0] xmag_c, ymag_c;

  logic signed [N:0]   xsum, ysum, xmid, ymid;
  logic signed [N+1:0] xc, yc;
  logic [N:0] xspan_w, yspan_w;

  logic mul_start, mul_done, mul_done_x;
  logic [PW-1:0] an, ad, big, small_v;
  logic cor_start, cor_done;
  logic [scch_pkg::ANG_W-1:0] t;
  logic [scch_pkg::PHI_W-1:0] phi1, phi2;
  logic [scch_pkg::HEAD_W-1:0] deg, heading;

  assign s_axis_tready = (state == S_IDLE) && !fin;

  // Recentering by truncated midpoint, spans and magnitudes.
  always_comb begin
    xsum    = $signed({x_max[N-1], x_max}) + $signed({x_min[N-1], x_min});
    ysum    = $signed({y_max[N-1], y_max}) + $signed({y_min[N-1], y_min});
    xmid    = xsum[N] ? ((xsum + $signed((N+1)'(1))) >>> 1) : (xsum >>> 1);
    ymid    = ysum[N] ? ((ysum + $signed((N+1)'(1))) >>> 1) : (ysum >>> 1);
    xc      = $signed({{2{xs[N-1]}}, xs}) - $signed({xmid[N], xmid});
    yc      = $signed({{2{ys[N-1]}}, ys}) - $signed({ymid[N], ymid});
    xspan_w = (N+1)'($signed({x_max[N-1], x_max}) - $signed({x_min[N-1], x_min}));
    yspan_w = (N+1)'($signed({y_max[N-1], y_max}) - $signed({y_min[N-1], y_min}));
    xmag_c  = xc[N+1] ? (N+1)'(-xc) : xc[N:0];
    ymag_c  = yc[N+1] ? (N+1)'(-yc) : yc[N:0];
    cal_c   = (x_min != x_max) && (y_min != y_max);
  end

  // Octant reduction and final fold to whole degrees.
  always_comb begin
    big     = (an > ad) ? an : ad;
    small_v = (an > ad) ? ad : an;
    phi1    = swap ? (scch_pkg::DEG90 - scch_pkg::PHI_W'(t)) : scch_pkg::PHI_W'(t);
    phi2    = den_neg ? (scch_pkg::DEG180 - phi1) : phi1;
    deg     = phi2[scch_pkg::PHI_W-1:scch_pkg::DEG_FRAC];
    if (num_neg) begin
      heading = scch_pkg::FULL_TURN - deg;
    end else if (deg == '0) begin
      heading = scch_pkg::FULL_TURN;
    end else begin
      heading = deg;
    end
  end

  assign mul_start = (state == S_CTR) && cal_c;
  assign cor_start = (state == S_OCT);

  scch_mult #(.AW(N + 1), .BW(N)) u_mult_y (
    .clk(clk), .rst(rst), .start(mul_start),
    .a(ymag_c), .b(xspan_w[N-1:0]), .done(mul_done), .prod(an)
  );

  scch_mult #(.AW(N + 1), .BW(N)) u_mult_x (
    .clk(clk), .rst(rst), .start(mul_start),
    .a(xmag_c), .b(yspan_w[N-1:0]), .done(mul_done_x), .prod(ad)
  );

  scch_cordic #(.BW(PW)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start),
    .big(big), .small_in(small_v), .done(cor_done), .angle(t)
  );

  // Sequencer and calibration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
      x_min <= '0;
      x_max <= '0;
      y_min <= '0;
      y_max <= '0;
      cal   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (xs < x_min) x_min <= xs;
          if (xs > x_max) x_max <= xs;
          if (ys < y_min) y_min <= ys;
          if (ys > y_max) y_max <= ys;
          state <= S_CTR;
        end
        S_CTR: begin
          cal <= cal_c;
          if (cal_c) begin
            state <= S_MUL;
          end else begin
            state <= S_IDLE;
            fin   <= 1'b1;
          end
        end
        S_MUL: begin
          if (mul_done) state <= S_OCT;
        end
        S_OCT: begin
          state <= S_COR;
        end
        S_COR: begin
          if (cor_done) begin
            state <= S_IDLE;
            fin   <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (fin && (!m_axis_tvalid || m_axis_tready)) begin
        fin <= 1'b0;
      end
    end
  end

  // Sample capture and per-sample working registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      xs <= $signed(s_axis_tdata[N-1:0]);
      ys <= $signed(s_axis_tdata[16+N-1:16]);
    end
    if (state == S_CTR) begin
      num_neg <= yc[N+1];
      den_neg <= xc[N+1];
    end
    if (state == S_OCT) begin
      swap <= an > ad;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fin && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= cal ? 16'(heading) : 16'd0;
      m_axis_tuser <= cal;
    end
  end

  // Checks on the core's own sequencing and results.
  `SCCH_ASSERT_IMP(a_uncal_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'd0)
  `SCCH_ASSERT_IMP(a_cal_range, m_axis_tvalid && m_axis_tuser,
                   (m_axis_tdata != 16'd0) && (m_axis_tdata <= 16'd360))
  `SCCH_ASSERT_IMP(a_mult_pair, mul_done, mul_done_x && (state == S_MUL))
  `SCCH_ASSERT_NXT(a_accept_seq, s_axis_tvalid && s_axis_tready, state == S_UPD)
endmodule
`default_nettype wire

// ----- hw/rtl/scch_mult.sv -----
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; instantiated twice by the top level.
`timescale 1ns / 1ps
`default_nettype none
module scch_mult #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      prod
);
  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] addend;
  logic [BW-1:0]    mbits;
  logic [CW-1:0]    cnt;
  logic             busy;

  // Control: count down one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: the multiplier shifts out low bit first, the multiplicand shifts up.
  always_ff @(posedge clk) begin
    if (start) begin
      prod   <= '0;
      addend <= (AW+BW)'(a);
      mbits  <= b;
    end else if (busy) begin
      if (mbits[0]) begin
        prod <= prod + addend;
      end
      addend <= addend << 1;
      mbits  <= mbits >> 1;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/scch_cordic.sv -----
// Iterative vectoring CORDIC giving the first-octant angle in Q16 degrees.
// Depends on scch_pkg for the arctangent table and fixed-point constants.
`timescale 1ns / 1ps
`default_nettype none
module scch_cordic #(
  parameter int BW = 33
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [BW-1:0]             big,
  input  wire logic [BW-1:0]             small_in,
  output logic                           done,
  output logic [scch_pkg::ANG_W-1:0]     angle
);
  localparam int CW = BW + scch_pkg::PRESCALE_BITS + 2;
  localparam int ZW = scch_pkg::Z_W;

  logic signed [CW-1:0] cx, cy, dx, dy, cx_next, cy_next;
  logic signed [ZW-1:0] z, z_next, step;
  logic [scch_pkg::ITER_W-1:0] it;
  logic busy;

  // One micro-rotation per cycle.
  always_comb begin
    dx   = cy >>> it;
    dy   = cx >>> it;
    step = $signed(ZW'(scch_pkg::atan_q16(it)));
    if (!cy[CW-1] && (cy != '0)) begin
      cx_next = cx + dx;
      cy_next = cy - dy;
      z_next  = z + step;
    end else begin
      cx_next = cx - dx;
      cy_next = cy + dy;
      z_next  = z - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        it <= '0;
        // On an axis or the diagonal the angle is exact.
        if (small_in == '0) begin
          angle <= '0;
          done  <= 1'b1;
        end else if (small_in == big) begin
          angle <= scch_pkg::DEG45;
          done  <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        it <= it + 1'b1;
        if (it == scch_pkg::ITER_W'(scch_pkg::ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          // Keep the angle strictly inside the octant.
          if (z_next < $signed(ZW'(1))) begin
            angle <= scch_pkg::ANG_W'(1);
          end else if (z_next > $signed(ZW'(scch_pkg::DEG45 - 1'b1))) begin
            angle <= scch_pkg::DEG45 - 1'b1;
          end else begin
            angle <= z_next[scch_pkg::ANG_W-1:0];
          end
        end
      end
    end
  end

  // Vector registers.
  always_ff @(posedge clk) begin
    if (start) begin
      cx <= $signed({2'b00, big, {scch_pkg::PRESCALE_BITS{1'b0}}});
      cy <= $signed({2'b00, small_in, {scch_pkg::PRESCALE_BITS{1'b0}}});
      z  <= '0;
    end else if (busy) begin
      cx <= cx_next;
      cy <= cy_next;
      z  <= z_next;
    end
  end
endmodule
`default_nettype wire
